// ===== hw/rtl/wsd_pkg.sv =====
// Shared types, codes and helpers for the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

	// Width of the length field that the parser accepts (16 to 64).
	localparam int LENGTH_BITS = 64;
	localparam logic [63:0] LEN_MASK = (LENGTH_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [62:0] MAX_LEN_RESET = 63'd67108864;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;

	localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [1:0] KIND_EMPTY     = 2'd1;
	localparam logic [1:0] KIND_TOO_LARGE = 2'd2;
	localparam logic [1:0] KIND_CONN_END  = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [3:0] msg_opcode;
		logic       is_control;
		logic       last_of_frame;
		logic       last_of_message;
	} result_t;

	typedef struct packed {
		logic       shown;
		logic [3:0] op;
		logic       ctl;
	} content_t;

	// Effective opcode of a frame and whether its content goes out.
	function automatic content_t content_shown(input logic [3:0] frame_op,
			input logic [3:0] frag_op);
		content_t c;
		if (frame_op[3]) begin
			c.op    = frame_op;
			c.ctl   = 1'b1;
			c.shown = (frame_op == OP_CLOSE) || (frame_op == OP_PING);
		end else begin
			c.op    = (frame_op == OP_CONT) ? frag_op : frame_op;
			c.ctl   = 1'b0;
			c.shown = (c.op == OP_TEXT) || (c.op == OP_BINARY);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_front.sv =====
// Header parser and unmasker: takes one stream beat per cycle when fire is high, pushes results.
`timescale 1ns / 1ps
`default_nettype none

module wsd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        in_byte,
	input  wire logic              stream_end,
	input  wire logic              cfg_we,
	input  wire logic [62:0]       cfg_wdata,
	output wsd_pkg::result_t       push_data,
	output logic                   push
);
	import wsd_pkg::*;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CLOSED  = 3'd5;

	logic [2:0]  phase_q, phase_n;
	logic [2:0]  fcount_q, fcount_n;
	logic        fin_q, fin_n;
	logic [3:0]  opcode_q, opcode_n;
	logic        masked_q, masked_n;
	logic [63:0] rem_q, rem_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  pos_q, pos_n;
	logic [3:0]  frag_q, frag_n;
	logic [62:0] max_len_q;

	logic       len_done, pay_start, done, last;
	logic [6:0] len7;
	logic [7:0] key_byte;
	content_t   cont;

	assign cont = content_shown(opcode_q, frag_q);

	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		fcount_n  = fcount_q;
		fin_n     = fin_q;
		opcode_n  = opcode_q;
		masked_n  = masked_q;
		rem_n     = rem_q;
		key_n     = key_q;
		pos_n     = pos_q;
		frag_n    = frag_q;
		push      = 1'b0;
		push_data = '0;
		len_done  = 1'b0;
		pay_start = 1'b0;
		done      = 1'b0;
		last      = 1'b0;
		len7      = in_byte[6:0];

		if (fire && phase_q != PH_CLOSED) begin
			if (stream_end) begin
				push           = 1'b1;
				push_data.kind = KIND_CONN_END;
				phase_n        = PH_CLOSED;
			end else begin
				unique case (phase_q)
					PH_HDR0: begin
						fin_n    = in_byte[7];
						opcode_n = in_byte[3:0];
						phase_n  = PH_HDR1;
					end
					PH_HDR1: begin
						masked_n = in_byte[7];
						key_n    = '0;
						if (len7 == 7'd126 || len7 == 7'd127) begin
							fcount_n = (len7 == 7'd126) ? 3'd1 : 3'd7;
							rem_n    = '0;
							phase_n  = PH_EXTLEN;
						end else begin
							rem_n    = {57'd0, len7};
							len_done = 1'b1;
						end
					end
					PH_EXTLEN: begin
						rem_n = {rem_q[55:0], in_byte};
						if (fcount_q == 3'd0) len_done = 1'b1;
						else fcount_n = fcount_q - 3'd1;
					end
					PH_MASK: begin
						key_n = {key_q[23:0], in_byte};
						if (fcount_q == 3'd0) pay_start = 1'b1;
						else fcount_n = fcount_q - 3'd1;
					end
					PH_PAYLOAD: begin
						pos_n = pos_q + 2'd1;
						rem_n = rem_q - 64'd1;
						last  = (rem_n == 64'd0);
						if (cont.shown) begin
							push                      = 1'b1;
							push_data.kind            = KIND_PAYLOAD;
							push_data.data_byte       = in_byte ^ key_byte;
							push_data.msg_opcode      = cont.op;
							push_data.is_control      = cont.ctl;
							push_data.last_of_frame   = last;
							push_data.last_of_message = last & fin_q;
						end
						done = last;
					end
					default: phase_n = PH_CLOSED;
				endcase

				if (len_done) begin
					if ((rem_n & ~LEN_MASK) != 64'd0 || rem_n > {1'b0, max_len_q}) begin
						push           = 1'b1;
						push_data.kind = KIND_TOO_LARGE;
						phase_n        = PH_CLOSED;
					end else if (masked_n) begin
						phase_n  = PH_MASK;
						fcount_n = 3'd3;
					end else begin
						pay_start = 1'b1;
					end
				end

				if (pay_start) begin
					pos_n = 2'd0;
					if (rem_n != 64'd0) begin
						phase_n = PH_PAYLOAD;
					end else begin
						if (cont.shown) begin
							push                      = 1'b1;
							push_data.kind            = KIND_EMPTY;
							push_data.msg_opcode      = cont.op;
							push_data.is_control      = cont.ctl;
							push_data.last_of_frame   = 1'b1;
							push_data.last_of_message = fin_q;
						end
						done = 1'b1;
					end
				end

				// Frame complete: settle the fragment state, close after a close frame.
				if (done) begin
					phase_n = PH_HDR0;
					if (opcode_q[3]) begin
						if (opcode_q == OP_CLOSE) phase_n = PH_CLOSED;
					end else if (opcode_q == OP_CONT) begin
						if (frag_q != OP_CONT && fin_q) frag_n = OP_CONT;
					end else if (!fin_q) begin
						frag_n = opcode_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			fcount_q  <= '0;
			fin_q     <= 1'b0;
			opcode_q  <= '0;
			masked_q  <= 1'b0;
			rem_q     <= '0;
			key_q     <= '0;
			pos_q     <= '0;
			frag_q    <= '0;
			max_len_q <= MAX_LEN_RESET;
		end else begin
			phase_q  <= phase_n;
			fcount_q <= fcount_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			rem_q    <= rem_n;
			key_q    <= key_n;
			pos_q    <= pos_n;
			frag_q   <= frag_n;
			if (cfg_we) max_len_q <= cfg_wdata;
		end
	end

	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("closed deframer reopened");

	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |-> !push)
		else $error("result pushed while closed");

	a_fatal_closes: assert property (@(posedge clk) disable iff (!arst_n)
		push && (push_data.kind == KIND_TOO_LARGE || push_data.kind == KIND_CONN_END)
		|=> phase_q == PH_CLOSED)
		else $error("error result without closing");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != 64'd0)
		else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_queue.sv =====
// Short result queue between the parser and the output stream.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wsd_pkg::result_t  push_data,
	output logic                   full,
	output logic                   valid,
	input  wire logic              pop,
	output wsd_pkg::result_t       head
);
	import wsd_pkg::*;

	result_t             slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_pop;

	assign full   = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign valid  = (count_q != '0);
	assign do_pop = pop & valid;
	assign head   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({push, do_pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full result queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("result queue count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: parser, result queue, stream ports.
//
// channel   dir  beat                         fields (low bit up)
// s_*       in   one stream byte              tdata: in_byte; tlast: stream_end
// m_*       out  one result item              tdata: data_byte, msg_opcode;
//                                             tuser: kind, is_control,
//                                             last_of_message; tlast: last_of_frame
// cfg_*     in   max_payload_len write        cfg_wdata: max_payload_len
//
// One input beat per cycle while s_tready is high; results go to m_* via the queue.
// s_tready drops only while the four-entry result queue is full.
// m_tready low stalls the output alone until the queue fills.
// arst_n clears the parser and the queue; max_payload_len returns to 64 MiB.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // stream_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] data_byte, [11:8] msg_opcode, rest zero
	output logic             m_tlast,   // last_of_frame
	output logic [3:0]       m_tuser,   // [1:0] kind, [2] is_control, [3] last_of_message
	input  wire logic        cfg_we,
	input  wire logic [62:0] cfg_wdata
);
	import wsd_pkg::*;

	logic    fire, push, full;
	result_t push_data, head;

	assign s_tready = !full;
	assign fire     = s_tvalid & s_tready;

	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.in_byte    (s_tdata),
		.stream_end (s_tlast),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push_data  (push_data),
		.push       (push)
	);

	wsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.valid     (m_tvalid),
		.pop       (m_tready),
		.head      (head)
	);

	assign m_tdata = {4'd0, head.msg_opcode, head.data_byte};
	assign m_tlast = head.last_of_frame;
	assign m_tuser = {head.last_of_message, head.is_control, head.kind};

endmodule

`default_nettype wire

// ===== tb/websocket_frame_deframer_tb.sv =====
// Self-checking testbench for the WebSocket frame deframer: frame traffic against a parser model.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
	import wsd_pkg::*;

	localparam logic [3:0]  OP_PONG    = 4'hA;
	localparam logic [3:0]  NO_MESSAGE = 4'h0;
	localparam int unsigned IDLE_LIMIT = 4000;

	typedef enum logic [2:0] {
		HDR_FIRST, HDR_LEN, EXT_LEN, MASK_KEY, PAYLOAD, CLOSED
	} parse_phase_t;

	typedef enum logic [1:0] {FORM_7, FORM_16, FORM_64} length_form_t;

	typedef enum logic [1:0] {
		READY_ALWAYS, READY_RANDOM, READY_PATTERN, READY_SPARSE
	} ready_mode_t;

	class deframer_scoreboard;
		logic [62:0]  len_limit;
		parse_phase_t phase;
		logic [2:0]   bytes_left;
		logic         fin;
		logic [3:0]   opcode;
		logic         masked;
		logic [63:0]  remaining;
		logic [31:0]  key;
		logic [1:0]   key_pos;
		logic [3:0]   open_opcode;
		logic         closed;
		result_t      expected_q[$];
		int unsigned  fail_count;

		function new();
			len_limit   = MAX_LEN_RESET;
			phase       = HDR_FIRST;
			bytes_left  = '0;
			fin         = 1'b0;
			opcode      = '0;
			masked      = 1'b0;
			remaining   = '0;
			key         = '0;
			key_pos     = '0;
			open_opcode = NO_MESSAGE;
			closed      = 1'b0;
			fail_count  = 0;
		endfunction

		function void set_limit(input logic [62:0] value);
			len_limit = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push(input logic [1:0] kind, input logic [7:0] data,
				input logic [3:0] op, input logic ctl, input logic lof, input logic lom);
			result_t r;
			r.kind            = kind;
			r.data_byte       = data;
			r.msg_opcode      = op;
			r.is_control      = ctl;
			r.last_of_frame   = lof;
			r.last_of_message = lom;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void shut();
			closed = 1'b1;
			phase  = CLOSED;
		endfunction

		// Continuations take the opcode of the open message; only text, binary,
		// ping and close content goes out.
		function logic visible(output logic [3:0] op, output logic ctl);
			if (opcode[3]) begin
				op  = opcode;
				ctl = 1'b1;
				return (opcode == OP_CLOSE) || (opcode == OP_PING);
			end
			op  = (opcode == OP_CONT) ? open_opcode : opcode;
			ctl = 1'b0;
			return (op == OP_TEXT) || (op == OP_BINARY);
		endfunction

		function void end_frame();
			phase = HDR_FIRST;
			if (opcode[3]) begin
				if (opcode == OP_CLOSE)
					shut();
			end else if (opcode == OP_CONT) begin
				if (open_opcode != NO_MESSAGE && fin)
					open_opcode = NO_MESSAGE;
			end else if (!fin) begin
				open_opcode = opcode;
			end
		endfunction

		function void begin_payload();
			logic [3:0] op;
			logic       ctl;
			key_pos = 2'd0;
			if (remaining != 64'd0) begin
				phase = PAYLOAD;
				return;
			end
			if (visible(op, ctl))
				push(KIND_EMPTY, 8'h00, op, ctl, 1'b1, fin);
			end_frame();
		endfunction

		function void length_complete();
			if ((remaining & ~LEN_MASK) != 64'd0 || remaining > {1'b0, len_limit}) begin
				push(KIND_TOO_LARGE, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
				shut();
			end else if (masked) begin
				phase      = MASK_KEY;
				bytes_left = 3'd3;
			end else begin
				begin_payload();
			end
		endfunction

		function void note_beat(input logic [7:0] b, input logic ended);
			logic [3:0] op;
			logic       ctl;
			logic [7:0] key_byte;
			logic       last;
			if (closed)
				return;
			if (ended) begin
				push(KIND_CONN_END, 8'h00, 4'h0, 1'b0, 1'b0, 1'b0);
				shut();
				return;
			end
			case (phase)
			HDR_FIRST: begin
				fin    = b[7];
				opcode = b[3:0];
				phase  = HDR_LEN;
			end
			HDR_LEN: begin
				masked    = b[7];
				key       = '0;
				remaining = {57'd0, b[6:0]};
				if (b[6:0] >= 7'd126) begin
					// 126 announces two length bytes, 127 eight
					bytes_left = b[0] ? 3'd7 : 3'd1;
					remaining  = '0;
					phase      = EXT_LEN;
				end else begin
					length_complete();
				end
			end
			EXT_LEN: begin
				remaining = {remaining[55:0], b};
				if (bytes_left == 3'd0)
					length_complete();
				else
					bytes_left = bytes_left - 3'd1;
			end
			MASK_KEY: begin
				key = {key[23:0], b};
				if (bytes_left == 3'd0)
					begin_payload();
				else
					bytes_left = bytes_left - 3'd1;
			end
			PAYLOAD: begin
				key_byte  = 8'(key >> (5'd24 - {key_pos, 3'b000}));
				key_pos   = key_pos + 2'd1;
				remaining = remaining - 64'd1;
				last      = (remaining == 64'd0);
				if (visible(op, ctl))
					push(KIND_PAYLOAD, b ^ key_byte, op, ctl, last, last && fin);
				if (last)
					end_frame();
			end
			default: shut();
			endcase
		endfunction

		function void compare(input string name, input logic [7:0] exp_v,
				input logic [7:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
				fail_count++;
			end
		endfunction

		function void check_result(input logic [15:0] tdata, input logic [3:0] tuser,
				input logic tlast);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: tdata=0x%0h tuser=0x%0h tlast=%0b",
					tdata, tuser, tlast);
				fail_count++;
				return;
			end
			e = expected_q.pop_front();
			compare("kind", 8'(e.kind), 8'(tuser[1:0]));
			compare("data_byte", e.data_byte, tdata[7:0]);
			compare("msg_opcode", 8'(e.msg_opcode), 8'(tdata[11:8]));
			compare("is_control", 8'(e.is_control), 8'(tuser[2]));
			compare("last_of_frame", 8'(e.last_of_frame), 8'(tlast));
			compare("last_of_message", 8'(e.last_of_message), 8'(tuser[3]));
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic [62:0] cfg_wdata = '0;

	deframer_scoreboard sb;
	int unsigned        beats_sent  = 0;
	int unsigned        burst_left  = 0;
	int unsigned        idle_cycles = 0;
	logic [62:0]        limit_now   = MAX_LEN_RESET;
	int unsigned        window_left = 0;
	ready_mode_t        ready_mode  = READY_ALWAYS;
	logic [7:0]         ready_pattern = 8'hFF;

	websocket_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser, m_tlast);
			if (s_tvalid && s_tready)
				sb.note_beat(s_tdata, s_tlast);
			if (cfg_we)
				sb.set_limit(cfg_wdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver: pick a fresh stall style for each window of cycles.
	always @(negedge clk) begin
		if (window_left == 0) begin
			window_left   = $urandom_range(16, 64);
			ready_pattern = 8'($urandom);
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6: ready_mode = READY_ALWAYS;
			7, 8, 9, 10, 11:     ready_mode = READY_RANDOM;
			12, 13, 14, 15, 16:  ready_mode = READY_PATTERN;
			default:             ready_mode = READY_SPARSE;
			endcase
		end
		window_left--;
		case (ready_mode)
		READY_ALWAYS:  m_tready = 1'b1;
		READY_RANDOM:  m_tready = 1'($urandom);
		READY_PATTERN: m_tready = ready_pattern[window_left[2:0]];
		default:       m_tready = ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_beat(input logic [7:0] b, input logic ended);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(100, 200);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap        = $urandom_range(0, 12);
			end
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				s_tdata  = 8'($urandom);
			end
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = ended;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		beats_sent++;
	endtask

	// Drop valid and let every outstanding result drain before touching the register.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [62:0] value);
		settle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		limit_now = value;
	endtask

	function automatic length_form_t pick_form(input logic [63:0] len);
		if (len > 64'd65535)
			return FORM_64;
		if (len > 64'd125)
			return ($urandom_range(0, 3) == 0) ? FORM_64 : FORM_16;
		case ($urandom_range(0, 9))
		0:       return FORM_16;
		1:       return FORM_64;
		default: return FORM_7;
		endcase
	endfunction

	function automatic logic [63:0] pick_len();
		logic [63:0] cap;
		cap = ($urandom_range(0, 19) == 0) ? 64'd300 : 64'd12;
		if ({1'b0, limit_now} < cap)
			cap = {1'b0, limit_now};
		return 64'($urandom_range(0, 32'(cap)));
	endfunction

	function automatic logic [3:0] pick_opcode();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return OP_TEXT;
		if (r < 48)
			return OP_BINARY;
		if (r < 66)
			return OP_CONT;
		if (r < 76)
			return OP_PING;
		if (r < 82)
			return OP_PONG;
		if (r < 91)
			return 4'($urandom_range(3, 7));
		return 4'($urandom_range(11, 15));
	endfunction

	task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
			input logic [63:0] len, input bit header_only);
		length_form_t form;
		logic [6:0]   len7;
		form = pick_form(len);
		len7 = (form == FORM_16) ? 7'd126 : (form == FORM_64) ? 7'd127 : len[6:0];
		send_beat({fin, 3'($urandom), op}, 1'b0);
		send_beat({masked, len7}, 1'b0);
		if (form == FORM_16) begin
			send_beat(len[15:8], 1'b0);
			send_beat(len[7:0], 1'b0);
		end
		if (form == FORM_64)
			for (int i = 7; i >= 0; i--)
				send_beat(len[8*i +: 8], 1'b0);
		if (header_only)
			return;
		if (masked)
			repeat (4) send_beat(8'($urandom), 1'b0);
		for (longint unsigned i = 0; i < len; i++)
			send_beat(8'($urandom), 1'b0);
	endtask

	// Message in one or more frames, now and then interleaved with ping
	// frames or a whole data frame of its own.
	task automatic send_message();
		int unsigned parts;
		parts = $urandom_range(0, 4);
		send_frame(parts == 0, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY,
			$urandom_range(0, 9) < 7, pick_len(), 1'b0);
		for (int unsigned i = 1; i <= parts; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_frame($urandom_range(0, 5) != 0, OP_PING, 1'($urandom), pick_len(), 1'b0);
			if ($urandom_range(0, 7) == 0)
				send_frame(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, 1'($urandom),
					pick_len(), 1'b0);
			send_frame(i == parts, OP_CONT, $urandom_range(0, 9) < 7, pick_len(), 1'b0);
		end
	endtask

	task automatic run_traffic(input int unsigned beats);
		int unsigned stop_at;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(0, 9) < 6)
				send_message();
			else
				send_frame($urandom_range(0, 3) != 0, pick_opcode(), $urandom_range(0, 9) < 7,
					pick_len(), 1'b0);
		end
	endtask

	task automatic run_directed();
		// empty text frame: marker only
		send_frame(1'b1, OP_TEXT, 1'b0, 64'd0, 1'b0);
		// masked binary, all-ones key over both byte extremes
		send_beat({1'b1, 3'b000, OP_BINARY}, 1'b0);
		send_beat(8'h82, 1'b0);
		repeat (4) send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		// continuation with no message open: drop silently
		send_frame(1'b1, OP_CONT, 1'b0, 64'd1, 1'b0);
		// fragmented text with a ping without FIN in the middle
		send_frame(1'b0, OP_TEXT, 1'b0, 64'd1, 1'b0);
		send_frame(1'b0, OP_PING, 1'b0, 64'd0, 1'b0);
		send_frame(1'b1, OP_CONT, 1'b0, 64'd0, 1'b0);
		// pong is consumed without output
		send_frame(1'b1, OP_PONG, 1'b0, 64'd1, 1'b0);
		// reserved data opcode opens a silent fragment
		send_frame(1'b0, 4'h5, 1'b0, 64'd0, 1'b0);
		send_frame(1'b1, OP_CONT, 1'b0, 64'd1, 1'b0);
	endtask

	// One terminating event per run: stream end, oversize length or close frame.
	task automatic run_shutdown();
		logic [63:0] len;
		logic [7:0]  frame_bytes[10];
		int unsigned cut;
		case ($urandom_range(0, 2))
		0: begin
			frame_bytes[0] = {1'b1, 3'b000, OP_TEXT};
			frame_bytes[1] = 8'h84;
			for (int i = 2; i < 10; i++)
				frame_bytes[i] = 8'($urandom);
			cut = $urandom_range(0, 9);
			for (int unsigned i = 0; i < cut; i++)
				send_beat(frame_bytes[i], 1'b0);
			send_beat(8'($urandom), 1'b1);
		end
		1: begin
			case ($urandom_range(0, 2))
			0:       write_limit(63'd0);
			1:       write_limit({63{1'b1}});
			default: write_limit(63'($urandom_range(1, 1000)));
			endcase
			len = {1'b0, limit_now} + 64'd1 + 64'($urandom_range(0, 3));
			send_frame(1'($urandom), pick_opcode(), 1'($urandom), len, 1'b1);
		end
		default: begin
			send_frame(1'($urandom), OP_CLOSE, 1'($urandom), pick_len(), 1'b0);
		end
		endcase
		// closed: everything after this is swallowed, stream end included
		repeat (8) send_beat(8'($urandom), 1'($urandom));
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_traffic(150);
		write_limit(63'd0);
		run_traffic(100);
		write_limit({63{1'b1}});
		run_traffic(250);
		write_limit(63'd1);
		run_traffic(100);
		write_limit(63'($urandom_range(2, 400)));
		run_traffic(250);
		write_limit({31'd0, 32'($urandom)});
		run_traffic(150);
		run_shutdown();

		settle();
		repeat (16) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
